### src/lfu_pkg.sv
package lfu_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int DATA_BITS   = 32;
    localparam logic [31:0] INIT_VISITS = 32'd255;
    localparam logic [31:0] AGE_MINUTES = 32'd10;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_STORE  = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_EVICT  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_ACT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]            command;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] store_value;
        logic [31:0]           now_minutes;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]            status;
        logic [DATA_BITS-1:0]  read_value;
        logic                  did_evict;
        logic [KEY_BITS-1:0]   evicted_key;
        logic [31:0]           hit_total;
        logic [31:0]           miss_total;
        logic [CNT_BITS-1:0]   occupancy;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic act;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic scan_last;
        logic weight_ready;
    } t_stat;

endpackage

### src/lfu_if.sv
interface lfu_in_if;
    logic               valid;
    logic               ready;
    lfu_pkg::t_in_beat  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lfu_out_if;
    logic               valid;
    logic               ready;
    lfu_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/lfu_aging_cache_table.sv
// Fully associative key/value table of 64 entries with least-frequently-used
// replacement and aging. Each input beat carries one command and yields one
// result beat. Every command walks all 64 slots one per cycle to find the key,
// the first free slot, the occupancy and the entry of least weight. The input
// is taken again while an earlier result still waits in the output register.
module lfu_aging_cache_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    lfu_in_if.sink      i_in,
    lfu_out_if.source   o_out
);

    lfu_pkg::t_ctrl w_ctrl;
    lfu_pkg::t_stat w_stat;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_ctrl      (w_ctrl)
    );

    lfu_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_beat     (i_in.payload),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .o_beat     (o_out.payload)
    );

endmodule

### src/lfu_ctrl.sv
module lfu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  lfu_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output lfu_pkg::t_ctrl  o_ctrl
);

    lfu_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            lfu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.start = 1'b1;
                    n_state      = lfu_pkg::S_SCAN;
                end
            end
            lfu_pkg::S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = lfu_pkg::S_DIV;
                end
            end
            lfu_pkg::S_DIV: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.weight_ready) begin
                    n_state = lfu_pkg::S_ACT;
                end
            end
            lfu_pkg::S_ACT: begin
                o_ctrl.act = 1'b1;
                n_state    = lfu_pkg::S_OUT;
            end
            lfu_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.load_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = lfu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/lfu_datapath.sv
module lfu_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    input  lfu_pkg::t_in_beat   i_beat,
    input  lfu_pkg::t_ctrl      i_ctrl,
    output lfu_pkg::t_stat      o_stat,
    output lfu_pkg::t_out_beat  o_beat
);

    localparam int D = lfu_pkg::DATA_BITS;

    logic [lfu_pkg::ENTRIES-1:0] r_valid;
    logic [lfu_pkg::KEY_BITS-1:0]   r_key   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::VALUE_BITS-1:0] r_value [lfu_pkg::ENTRIES];
    logic [31:0]                    r_visits[lfu_pkg::ENTRIES];
    logic [31:0]                    r_stamp [lfu_pkg::ENTRIES];

    logic [6:0]                     r_cap;
    logic [31:0]                    r_hits, r_miss;
    lfu_pkg::t_in_beat              r_in;
    logic [lfu_pkg::CNT_BITS-1:0]   r_idx;
    logic                           r_found;
    logic [lfu_pkg::IDX_BITS-1:0]   r_fidx;
    logic                           r_free_ok;
    logic [lfu_pkg::IDX_BITS-1:0]   r_free;
    logic [lfu_pkg::CNT_BITS-1:0]   r_count;
    logic                           r_best_ok;
    logic [lfu_pkg::IDX_BITS-1:0]   r_best;
    logic [31:0]                    r_bw;
    logic                           r_pend;
    logic [lfu_pkg::IDX_BITS-1:0]   r_pidx;
    logic [31:0]                    r_pvis;
    logic [31:0]                    r_page;
    logic                           r_pvalid;
    lfu_pkg::t_out_beat             r_res, r_obeat;

    logic [lfu_pkg::IDX_BITS-1:0]   w_i;
    logic                           w_last;
    logic [31:0]                    w_age_div;
    logic [31:0]                    w_weight;
    logic [63:0]                    w_prod;
    logic [6:0]                     w_cap;

    assign w_i    = r_idx[lfu_pkg::IDX_BITS-1:0];
    assign w_last = (r_idx == lfu_pkg::CNT_BITS'(lfu_pkg::ENTRIES - 1));
    assign o_stat.scan_last    = w_last;
    assign o_stat.weight_ready = !r_pend;

    // Age divided by ten via reciprocal multiply with one correction step.
    assign w_prod    = {32'd0, r_page} * 64'hCCCC_CCCD;
    always_comb begin
        w_age_div = w_prod[63:35];
        if (r_page - w_age_div * lfu_pkg::AGE_MINUTES >= lfu_pkg::AGE_MINUTES) begin
            w_age_div = w_age_div + 32'd1;
        end
        w_weight = (r_pvis > w_age_div) ? r_pvis - w_age_div : 32'd0;
    end

    always_comb begin
        w_cap = r_cap;
        if (w_cap == 7'd0) begin
            w_cap = 7'd1;
        end
        if (w_cap > 7'(lfu_pkg::ENTRIES)) begin
            w_cap = 7'(lfu_pkg::ENTRIES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 7'd64;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_in      <= i_beat;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_count   <= '0;
            r_best_ok <= 1'b0;
            r_pend    <= 1'b0;
            r_pvalid  <= 1'b0;
        end else if (i_ctrl.scan_step) begin
            r_pend <= 1'b0;
            if (r_pvalid) begin
                if (!r_best_ok || w_weight < r_bw) begin
                    r_best_ok <= 1'b1;
                    r_best    <= r_pidx;
                    r_bw      <= w_weight;
                end
            end
            r_pvalid <= 1'b0;
            if (r_pend || !w_last || r_idx[lfu_pkg::CNT_BITS-1] == 1'b0) begin
                if (r_idx < lfu_pkg::CNT_BITS'(lfu_pkg::ENTRIES)) begin
                    r_idx <= r_idx + 1'b1;
                    if (r_valid[w_i]) begin
                        r_count  <= r_count + 1'b1;
                        r_pvalid <= 1'b1;
                        r_pend   <= 1'b1;
                        r_pidx   <= w_i;
                        r_pvis   <= r_visits[w_i];
                        r_page   <= r_in.now_minutes - r_stamp[w_i];
                        if (!r_found && r_key[w_i] == r_in.lookup_key) begin
                            r_found <= 1'b1;
                            r_fidx  <= w_i;
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= w_i;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
        end else if (i_ctrl.act) begin
            r_res            <= '0;
            r_res.occupancy  <= r_count;
            r_res.hit_total  <= r_hits;
            r_res.miss_total <= r_miss;
            case (lfu_pkg::t_cmd'(r_in.command))
                lfu_pkg::CMD_LOOKUP: begin
                    if (r_found) begin
                        if (r_visits[r_fidx] != 32'hFFFF_FFFF) begin
                            r_visits[r_fidx] <= r_visits[r_fidx] + 32'd1;
                        end
                        r_stamp[r_fidx]   <= r_in.now_minutes;
                        r_hits            <= r_hits + 32'd1;
                        r_res.hit_total   <= r_hits + 32'd1;
                        r_res.read_value  <= D'(r_value[r_fidx]);
                    end else begin
                        r_miss           <= r_miss + 32'd1;
                        r_res.miss_total <= r_miss + 32'd1;
                        r_res.status     <= lfu_pkg::ST_NOT_FOUND;
                    end
                end
                lfu_pkg::CMD_STORE: begin
                    if (r_found) begin
                        r_value[r_fidx] <= r_in.store_value;
                    end else if (r_count >= w_cap && r_best_ok) begin
                        r_res.did_evict   <= 1'b1;
                        r_res.evicted_key <= r_key[r_best];
                        r_valid[r_best]   <= 1'b1;
                        r_key[r_best]     <= r_in.lookup_key;
                        r_value[r_best]   <= r_in.store_value;
                        r_visits[r_best]  <= lfu_pkg::INIT_VISITS;
                        r_stamp[r_best]   <= r_in.now_minutes;
                        if (r_free_ok && r_free < r_best) begin
                            r_valid[r_best]  <= 1'b0;
                            r_valid[r_free]  <= 1'b1;
                            r_key[r_free]    <= r_in.lookup_key;
                            r_value[r_free]  <= r_in.store_value;
                            r_visits[r_free] <= lfu_pkg::INIT_VISITS;
                            r_stamp[r_free]  <= r_in.now_minutes;
                        end
                    end else if (r_free_ok) begin
                        r_valid[r_free]  <= 1'b1;
                        r_key[r_free]    <= r_in.lookup_key;
                        r_value[r_free]  <= r_in.store_value;
                        r_visits[r_free] <= lfu_pkg::INIT_VISITS;
                        r_stamp[r_free]  <= r_in.now_minutes;
                        r_res.occupancy  <= r_count + 1'b1;
                    end
                end
                lfu_pkg::CMD_REMOVE: begin
                    if (r_found) begin
                        r_valid[r_fidx] <= 1'b0;
                        r_res.occupancy <= r_count - 1'b1;
                    end else begin
                        r_res.status <= lfu_pkg::ST_NOT_FOUND;
                    end
                end
                lfu_pkg::CMD_EVICT: begin
                    if (r_best_ok) begin
                        r_valid[r_best]   <= 1'b0;
                        r_res.did_evict   <= 1'b1;
                        r_res.evicted_key <= r_key[r_best];
                        r_res.occupancy   <= r_count - 1'b1;
                    end else begin
                        r_res.status <= lfu_pkg::ST_EMPTY;
                    end
                end
                lfu_pkg::CMD_CLEAR: begin
                    r_valid          <= '0;
                    r_hits           <= '0;
                    r_miss           <= '0;
                    r_res.hit_total  <= '0;
                    r_res.miss_total <= '0;
                    r_res.occupancy  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_obeat <= r_res;
        end
    end

    assign o_beat = r_obeat;

endmodule

### src/lfu_checker.sv
module lfu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input lfu_pkg::t_out_beat i_out_payload
);

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_payload.occupancy <= 7'd64) else $error("occupancy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_payload.status != 2'd3) else $error("status");

    a_evict_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_payload.did_evict) |-> i_out_payload.evicted_key == '0)
        else $error("evict key");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready) else $error("busy");

endmodule

bind lfu_aging_cache_table lfu_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
